@@ hdl/block_first_match_downscaler_assert.svh @@
// ----------------------------------------------------------------------------
// block_first_match_downscaler_assert.svh
// Assertion macros shared by the cfg, fifo and back modules. They expect clk and rst
// in scope.
// ----------------------------------------------------------------------------
`ifndef BLOCK_FIRST_MATCH_DOWNSCALER_ASSERT_SVH
`define BLOCK_FIRST_MATCH_DOWNSCALER_ASSERT_SVH

// same-cycle implication
`define BFMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bfmd_pkg.sv @@
// ----------------------------------------------------------------------------
// bfmd_pkg
// Types and constants of the block first-match downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfmd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_SCALE   = 16;
  localparam int LINE_AW     = $clog2(MAX_WIDTH);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_STEPS   = 12;

  localparam logic [2:0] REG_MATCH_MODE     = 3'd0;
  localparam logic [2:0] REG_GRAY_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_LABEL_KEY      = 3'd2;
  localparam logic [2:0] REG_BLOCK_SCALE    = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT   = 3'd5;

  typedef struct packed {
    logic [7:0]  gray_pixel;
    logic [15:0] pixel_label;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_pixel;
    logic       out_row_end;
    logic       frame_end;
  } pix_out_t;

  // settings and derived geometry, the front of the pipe sees this
  typedef struct packed {
    logic        match_mode;
    logic [7:0]  gray_threshold;
    logic [15:0] label_key;
    logic [4:0]  scale;
    logic [11:0] width;
    logic [11:0] height;
    logic [11:0] out_cols;
    logic [11:0] col_limit;
    logic [11:0] row_limit;
    logic [11:0] last_row_start;
    logic        busy;
  } cfg_t;

  typedef struct packed {
    logic [LINE_AW-1:0] addr;
    logic [7:0]         gray;
    logic               hit;
    logic               first;
    logic               last;
    logic               row_end;
    logic               frame_end;
  } q_item_t;

  typedef enum logic [1:0] {
    G_IDLE,
    G_LOAD,
    G_DIV,
    G_FINISH
  } geo_state_t;

endpackage

`default_nettype wire

@@ hdl/bfmd_cfg.sv @@
// ----------------------------------------------------------------------------
// bfmd_cfg
// Register file and geometry unit: clamps the settings and finds the block
// counts and covered region with two restoring dividers stepped together.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmd_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output bfmd_pkg::cfg_t     cfg
);
  import bfmd_pkg::*;

  `include "block_first_match_downscaler_assert.svh"

  logic        match_mode;
  logic [7:0]  gray_threshold;
  logic [15:0] label_key;
  logic [4:0]  block_scale;
  logic [11:0] image_width;
  logic [11:0] image_height;

  logic [4:0]  s_eff;
  logic [11:0] w_eff;
  logic [11:0] h_eff;

  geo_state_t  state, state_next;
  logic [3:0]  div_cnt;
  logic [11:0] wq, hq;
  logic [4:0]  wr, hr;
  logic [4:0]  wr_sh, hr_sh;
  logic        w_ge, h_ge;
  logic [11:0] out_cols, col_limit, row_limit, last_row_start;
  logic        busy;
  logic        wr_en;
  logic        geo_write;

  assign wr_en     = cfg_valid && cfg_ready;
  assign geo_write = wr_en && (cfg_index == REG_BLOCK_SCALE ||
                               cfg_index == REG_IMAGE_WIDTH ||
                               cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_mode     <= 1'b0;
      gray_threshold <= 8'd0;
      label_key      <= 16'd0;
      block_scale    <= 5'd2;
      image_width    <= 12'd640;
      image_height   <= 12'd480;
    end else if (wr_en) begin
      case (cfg_index)
        REG_MATCH_MODE:     match_mode     <= cfg_data[0];
        REG_GRAY_THRESHOLD: gray_threshold <= cfg_data[7:0];
        REG_LABEL_KEY:      label_key      <= cfg_data;
        REG_BLOCK_SCALE:    block_scale    <= cfg_data[4:0];
        REG_IMAGE_WIDTH:    image_width    <= cfg_data[11:0];
        REG_IMAGE_HEIGHT:   image_height   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_scale == 5'd0) begin
      s_eff = 5'd1;
    end else if (block_scale > 5'(MAX_SCALE)) begin
      s_eff = 5'(MAX_SCALE);
    end else begin
      s_eff = block_scale;
    end
    if (image_width == 12'd0) begin
      w_eff = 12'd1;
    end else if (image_width > 12'(MAX_WIDTH)) begin
      w_eff = 12'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == 12'd0) ? 12'd1 : image_height;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      G_IDLE:   if (geo_write) state_next = G_LOAD;
      G_LOAD:   state_next = G_DIV;
      G_DIV:    if (div_cnt == 4'(DIV_STEPS - 1)) state_next = G_FINISH;
      G_FINISH: state_next = G_IDLE;
      default:  state_next = G_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state != G_IDLE);
    cfg_ready = !busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= G_LOAD;
    end else begin
      state <= state_next;
    end
  end

  assign wr_sh = {wr[3:0], wq[11]};
  assign hr_sh = {hr[3:0], hq[11]};
  assign w_ge  = wr_sh >= s_eff;
  assign h_ge  = hr_sh >= s_eff;

  always_ff @(posedge clk) begin
    case (state)
      G_LOAD: begin
        wq      <= w_eff;
        hq      <= h_eff;
        wr      <= 5'd0;
        hr      <= 5'd0;
        div_cnt <= 4'd0;
      end
      G_DIV: begin
        wq      <= {wq[10:0], w_ge};
        hq      <= {hq[10:0], h_ge};
        wr      <= w_ge ? wr_sh - s_eff : wr_sh;
        hr      <= h_ge ? hr_sh - s_eff : hr_sh;
        div_cnt <= div_cnt + 4'd1;
      end
      G_FINISH: begin
        out_cols       <= wq;
        col_limit      <= w_eff - {7'd0, wr};
        row_limit      <= h_eff - {7'd0, hr};
        last_row_start <= h_eff - {7'd0, hr} - {7'd0, s_eff};
      end
      default: ;
    endcase
  end

  always_comb begin
    cfg.match_mode     = match_mode;
    cfg.gray_threshold = gray_threshold;
    cfg.label_key      = label_key;
    cfg.scale          = s_eff;
    cfg.width          = w_eff;
    cfg.height         = h_eff;
    cfg.out_cols       = out_cols;
    cfg.col_limit      = col_limit;
    cfg.row_limit      = row_limit;
    cfg.last_row_start = last_row_start;
    cfg.busy           = busy;
  end

  `BFMD_ASSERT_NEXT(a_geo_write_busy, geo_write, busy, "geometry write did not start divider")
  `BFMD_ASSERT_NEXT(a_finish_idle, state == G_FINISH, state == G_IDLE, "divider did not finish")

endmodule

`default_nettype wire

@@ hdl/bfmd_front.sv @@
// ----------------------------------------------------------------------------
// bfmd_front
// Raster position tracking and pixel classification; queues pixels that fall
// inside whole blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmd_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pixel_valid,
  output logic                   pixel_stall,
  input  wire bfmd_pkg::pix_in_t pixel,
  input  wire bfmd_pkg::cfg_t    cfg,
  input  wire logic              q_full,
  output logic                   q_push,
  output bfmd_pkg::q_item_t      q_item
);
  import bfmd_pkg::*;

  logic [LINE_AW-1:0] column_count;
  logic [11:0]        row_count;
  logic [3:0]         column_in_block;
  logic [3:0]         row_in_block;
  logic [LINE_AW-1:0] output_column;

  logic [LINE_AW-1:0] column_count_next;
  logic [11:0]        row_count_next;
  logic [3:0]         column_in_block_next;
  logic [3:0]         row_in_block_next;
  logic [LINE_AW-1:0] output_column_next;

  logic        accept;
  logic [4:0]  cib_inc, rib_inc, scale_m1;
  logic [11:0] cc_inc;
  logic [12:0] rc_inc;
  logic        in_region, hit, row_end;

  assign pixel_stall = cfg.busy || q_full;
  assign accept      = pixel_valid && !pixel_stall;

  assign cib_inc  = {1'b0, column_in_block} + 5'd1;
  assign rib_inc  = {1'b0, row_in_block} + 5'd1;
  assign cc_inc   = {1'b0, column_count} + 12'd1;
  assign rc_inc   = {1'b0, row_count} + 13'd1;
  assign scale_m1 = cfg.scale - 5'd1;

  assign in_region = ({1'b0, column_count} < cfg.col_limit) && (row_count < cfg.row_limit);
  assign hit = cfg.match_mode ? (pixel.pixel_label == cfg.label_key)
                              : (pixel.gray_pixel > cfg.gray_threshold);
  assign row_end = (({1'b0, output_column} + 12'd1) == cfg.out_cols);

  always_comb begin
    q_push            = accept && in_region;
    q_item.addr       = output_column;
    q_item.gray       = pixel.gray_pixel;
    q_item.hit        = hit;
    q_item.first      = (column_in_block == 4'd0) && (row_in_block == 4'd0);
    q_item.last       = ({1'b0, column_in_block} == scale_m1) &&
                        ({1'b0, row_in_block} == scale_m1);
    q_item.row_end    = row_end;
    q_item.frame_end  = row_end && (row_count >= cfg.last_row_start);
  end

  always_comb begin
    column_count_next    = column_count;
    row_count_next       = row_count;
    column_in_block_next = column_in_block;
    row_in_block_next    = row_in_block;
    output_column_next   = output_column;
    if (cib_inc >= cfg.scale) begin
      column_in_block_next = 4'd0;
      output_column_next   = output_column + LINE_AW'(1);
    end else begin
      column_in_block_next = cib_inc[3:0];
    end
    if (cc_inc >= cfg.width) begin
      column_count_next    = '0;
      column_in_block_next = 4'd0;
      output_column_next   = '0;
      row_in_block_next    = (rib_inc >= cfg.scale) ? 4'd0 : rib_inc[3:0];
      if (rc_inc >= {1'b0, cfg.height}) begin
        row_count_next    = 12'd0;
        row_in_block_next = 4'd0;
      end else begin
        row_count_next = rc_inc[11:0];
      end
    end else begin
      column_count_next = cc_inc[LINE_AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= 12'd0;
      column_in_block <= 4'd0;
      row_in_block    <= 4'd0;
      output_column   <= '0;
    end else if (accept) begin
      column_count    <= column_count_next;
      row_count       <= row_count_next;
      column_in_block <= column_in_block_next;
      row_in_block    <= row_in_block_next;
      output_column   <= output_column_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bfmd_fifo.sv @@
// ----------------------------------------------------------------------------
// bfmd_fifo
// Short queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bfmd_pkg::q_item_t push_item,
  output logic                   full,
  output logic                   head_valid,
  output bfmd_pkg::q_item_t      head_item,
  input  wire logic              pop
);
  import bfmd_pkg::*;

  `include "block_first_match_downscaler_assert.svh"

  q_item_t            slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `BFMD_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
  `BFMD_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

`default_nettype wire

@@ hdl/bfmd_back.sv @@
// ----------------------------------------------------------------------------
// bfmd_back
// Line store read-modify-write per queued pixel and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfmd_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire bfmd_pkg::q_item_t head_item,
  output logic                   pop,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output bfmd_pkg::pix_out_t     result
);
  import bfmd_pkg::*;

  `include "block_first_match_downscaler_assert.svh"

  logic [8:0]         line_mem [MAX_WIDTH];
  logic [8:0]         rdata;
  q_item_t            b_item;
  logic               b_valid;
  logic               lw_valid;
  logic [LINE_AW-1:0] lw_addr;
  logic [8:0]         lw_data;
  logic [8:0]         old_entry, entry;
  logic               b_done;

  // last write covers the one the registered read could not see
  assign old_entry = (lw_valid && lw_addr == b_item.addr) ? lw_data : rdata;

  always_comb begin
    if (b_item.first) begin
      entry = b_item.hit ? {1'b1, b_item.gray} : 9'd0;
    end else if (!old_entry[8] && b_item.hit) begin
      entry = {1'b1, b_item.gray};
    end else begin
      entry = old_entry;
    end
  end

  assign b_done = b_valid && (!b_item.last || !result_valid || !result_stall);
  assign pop    = head_valid && (!b_valid || b_done);

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata  <= line_mem[head_item.addr];
      b_item <= head_item;
    end
    if (b_done) begin
      line_mem[b_item.addr] <= entry;
      lw_addr               <= b_item.addr;
      lw_data               <= entry;
    end
    if (b_done && b_item.last) begin
      result.out_pixel   <= entry[8] ? entry[7:0] : 8'd0;
      result.out_row_end <= b_item.row_end;
      result.frame_end   <= b_item.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      lw_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_done) begin
        b_valid <= 1'b0;
      end
      if (b_done) lw_valid <= 1'b1;
      if (b_done && b_item.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `BFMD_ASSERT_NEXT(a_hold_blocked, b_valid && !b_done, b_valid, "pending pixel lost")
  `BFMD_ASSERT_NEXT(a_emit_shows, b_done && b_item.last, result_valid, "result not presented")

endmodule

`default_nettype wire

@@ hdl/block_first_match_downscaler.sv @@
// ----------------------------------------------------------------------------
// block_first_match_downscaler
// Reduces each scale-by-scale block of a raster image to the gray value of
// its first qualifying pixel, or to zero when none qualifies.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while pixel_stall is low. A block's result goes
// through the queue, line-store stage and output register once its
// bottom-right pixel is taken. After reset and each write to block_scale,
// image_width or image_height, the geometry divider's load state, 12 divide
// steps and finish state keep pixel_stall high and cfg_ready low. The line
// store is one 2048 x 9 memory with one read and one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_first_match_downscaler (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               pixel_valid,
  output logic                    pixel_stall,
  input  wire bfmd_pkg::pix_in_t  pixel,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output bfmd_pkg::pix_out_t      result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import bfmd_pkg::*;

  cfg_t    cfg;
  logic    q_full, q_push, head_valid, pop;
  q_item_t q_item, head_item;

  bfmd_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bfmd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (q_item)
  );

  bfmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_item),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  bfmd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_item    (head_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

@@ tb/sv/block_first_match_downscaler_tb.sv @@
// ----------------------------------------------------------------------------
// block_first_match_downscaler_tb
// Self-checking bench for the block first-match downscaler. Pixel frames are
// driven in raster order through the valid/stall port with random bursts and
// gaps, while the result side stalls on its own pattern. A scoreboard
// predicts the output pixel of every complete block and compares each result
// transfer, in order, against it. Register writes go in only while the block
// is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_first_match_downscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bfmd_pkg::*;

  class first_match_scoreboard;
    logic        cfg_mode;
    logic [7:0]  cfg_thresh;
    logic [15:0] cfg_key;
    logic [4:0]  cfg_scale;
    logic [11:0] cfg_width;
    logic [11:0] cfg_height;

    logic [11:0] col_pos;
    logic [11:0] row_pos;
    logic [3:0]  col_in_blk;
    logic [3:0]  row_in_blk;
    logic [10:0] blk_col;
    logic [8:0]  line_mem [MAX_WIDTH];   // bit 8 found, 7:0 gray

    pix_out_t expected_blocks[$];
    int       mismatches;

    function new();
      cfg_mode   = 1'b0;
      cfg_thresh = 8'd0;
      cfg_key    = 16'd0;
      cfg_scale  = 5'd2;
      cfg_width  = 12'd640;
      cfg_height = 12'd480;
      col_pos    = '0;
      row_pos    = '0;
      col_in_blk = '0;
      row_in_blk = '0;
      blk_col    = '0;
      mismatches = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    function int scale_in_use();
      if (cfg_scale == 0) return 1;
      if (cfg_scale > MAX_SCALE) return MAX_SCALE;
      return int'(cfg_scale);
    endfunction

    function int width_in_use();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
      return int'(cfg_width);
    endfunction

    function int height_in_use();
      return (cfg_height == 0) ? 1 : int'(cfg_height);
    endfunction

    function int frame_size();
      return width_in_use() * height_in_use();
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        REG_MATCH_MODE:     cfg_mode   = data[0];
        REG_GRAY_THRESHOLD: cfg_thresh = data[7:0];
        REG_LABEL_KEY:      cfg_key    = data;
        REG_BLOCK_SCALE:    cfg_scale  = data[4:0];
        REG_IMAGE_WIDTH:    cfg_width  = data[11:0];
        REG_IMAGE_HEIGHT:   cfg_height = data[11:0];
        default: ;
      endcase
    endfunction

    function void accept_pixel(pix_in_t p);
      int       s;
      int       w;
      int       h;
      int       ocols;
      int       orows;
      bit       hit;
      logic [8:0] entry;
      pix_out_t want;
      s     = scale_in_use();
      w     = width_in_use();
      h     = height_in_use();
      ocols = w / s;
      orows = h / s;
      if (int'(col_pos) < ocols * s && int'(row_pos) < orows * s) begin
        hit   = cfg_mode ? (p.pixel_label == cfg_key) : (p.gray_pixel > cfg_thresh);
        entry = line_mem[blk_col];
        if (row_in_blk == 0 && col_in_blk == 0) begin
          entry = hit ? {1'b1, p.gray_pixel} : 9'd0;
        end else if (!entry[8] && hit) begin
          entry = {1'b1, p.gray_pixel};
        end
        line_mem[blk_col] = entry;
        if (int'(col_in_blk) == s - 1 && int'(row_in_blk) == s - 1) begin
          want.out_pixel   = entry[8] ? entry[7:0] : 8'd0;
          want.out_row_end = (int'(blk_col) + 1 == ocols);
          want.frame_end   = want.out_row_end && (int'(row_pos) / s + 1 == orows);
          expected_blocks.push_back(want);
        end
      end
      if (int'(col_in_blk) + 1 >= s) begin
        col_in_blk = '0;
        blk_col    = blk_col + 11'd1;
      end else begin
        col_in_blk = col_in_blk + 4'd1;
      end
      if (int'(col_pos) + 1 >= w) begin
        col_pos    = '0;
        col_in_blk = '0;
        blk_col    = '0;
        if (int'(row_in_blk) + 1 >= s) row_in_blk = '0;
        else row_in_blk = row_in_blk + 4'd1;
        if (int'(row_pos) + 1 >= h) begin
          row_pos    = '0;
          row_in_blk = '0;
        end else begin
          row_pos = row_pos + 12'd1;
        end
      end else begin
        col_pos = col_pos + 12'd1;
      end
    endfunction

    function void report(string what, pix_out_t want, pix_out_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected pixel %0d row_end %b frame_end %b, got pixel %0d row_end %b frame_end %b",
                 $time, what, want.out_pixel, want.out_row_end, want.frame_end,
                 got.out_pixel, got.out_row_end, got.frame_end);
    endfunction

    function void compare_block(pix_out_t got);
      pix_out_t want;
      if (expected_blocks.size() == 0) begin
        report("result with no block pending", '0, got);
      end else begin
        want = expected_blocks.pop_front();
        if (got.out_pixel !== want.out_pixel || got.out_row_end !== want.out_row_end ||
            got.frame_end !== want.frame_end)
          report("block result differs", want, got);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  pix_in_t     pixel = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  pix_out_t    result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_MATCH_MODE;
  logic [15:0] cfg_data = '0;

  first_match_scoreboard sb = new();

  int burst_left = 0;
  bit gaps_on = 1'b1;
  int label_odds = 3;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int seg_left = 0;
  int seg_kind = 0;
  int random_items = 0;

  block_first_match_downscaler DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pix_in_t make_pixel();
    pix_in_t p;
    case ($urandom_range(0, 7))
      0: p.gray_pixel = 8'd0;
      1: p.gray_pixel = 8'd255;
      default: p.gray_pixel = 8'($urandom_range(0, 255));
    endcase
    p.pixel_label = ($urandom_range(0, label_odds) == 0) ? sb.cfg_key
                                                          : 16'($urandom_range(0, 65535));
    return p;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // nothing pending, then let trailing non-result pixels leave the pipe
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.expected_blocks.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic configure(input logic mode, input logic [7:0] thresh,
                           input logic [15:0] key, input logic [4:0] scale,
                           input logic [11:0] width, input logic [11:0] height);
    settle();
    write_reg(REG_MATCH_MODE, 16'(mode));
    write_reg(REG_GRAY_THRESHOLD, 16'(thresh));
    write_reg(REG_LABEL_KEY, key);
    write_reg(REG_BLOCK_SCALE, 16'(scale));
    write_reg(REG_IMAGE_WIDTH, 16'(width));
    write_reg(REG_IMAGE_HEIGHT, 16'(height));
    cfg_valid <= 1'b0;
  endtask

  task automatic offer_pixel(input pix_in_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pixel_valid <= 1'b1;
    pixel       <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    sb.accept_pixel(p);
  endtask

  task automatic send_pixels(input int count);
    repeat (count) offer_pixel(make_pixel());
  endtask

  // result side: check each transfer, then pick the stall for the next edge
  initial begin
    forever begin
      @(posedge clk);
      if (result_valid && !result_stall) sb.compare_block(result);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
        result_stall <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          seg_kind = $urandom_range(0, 4);
          seg_left = $urandom_range(20, 200);
        end
        seg_left--;
        case (seg_kind)
          0: result_stall <= 1'b0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= 1'($urandom_range(0, 1));
          3: result_stall <= ($urandom_range(0, 3) != 0);
          default: result_stall <= seg_left[3];
        endcase
      end
    end
  end

  initial begin
    int          frames;
    int          n;
    int          pick;
    int          s_eff;
    logic        mode;
    logic [7:0]  thresh;
    logic [15:0] key;
    logic [4:0]  scale;
    logic [11:0] width;
    logic [11:0] height;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of mode, threshold and scale left in place
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_IMAGE_HEIGHT, 16'd4);
    cfg_valid <= 1'b0;
    send_pixels(16);

    // scale zero acts as one
    configure(1'b1, 8'd0, 16'hFFFF, 5'd0, 12'd3, 12'd2);
    send_pixels(6);
    // zero width and height act as one
    configure(1'b1, 8'd0, 16'h0000, 5'd1, 12'd0, 12'd0);
    send_pixels(1);
    // oversize scale clamps to the maximum
    configure(1'b0, 8'd0, 16'h5A5A, 5'd31, 12'd16, 12'd16);
    send_pixels(256);
    // nothing can exceed the top threshold
    configure(1'b0, 8'd255, 16'h0001, 5'd2, 12'd4, 12'd4);
    send_pixels(16);
    // narrower and shorter than one block
    configure(1'b0, 8'h80, 16'h0000, 5'd4, 12'd3, 12'd8);
    send_pixels(24);
    configure(1'b1, 8'h00, 16'hA5A5, 5'd4, 12'd8, 12'd3);
    send_pixels(24);

    // geometry change at a block-row boundary mid-frame
    configure(1'b0, 8'd100, 16'h1234, 5'd2, 12'd6, 12'd6);
    send_pixels(12);
    settle();
    write_reg(REG_BLOCK_SCALE, 16'd1);
    write_reg(REG_IMAGE_WIDTH, 16'd4);
    write_reg(REG_GRAY_THRESHOLD, 16'd50);
    cfg_valid <= 1'b0;
    send_pixels(16);

    // height cut below the current row: rest of the row is dropped
    configure(1'b1, 8'd0, 16'hBEEF, 5'd2, 12'd4, 12'd8);
    send_pixels(16);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    cfg_valid <= 1'b0;
    send_pixels(12);

    // oversize width clamps to the line store depth
    configure(1'b0, 8'h40, 16'h0000, 5'd1, 12'd4095, 12'd1);
    send_pixels(2048);

    // long receiver hold with the sender streaming
    configure(1'b0, 8'h10, 16'h0000, 5'd1, 12'd16, 12'd16);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_pixels(256);
    gaps_on = 1'b1;

    while (random_items < 1250) begin
      mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: thresh = 8'd0;
        1: thresh = 8'd255;
        2: thresh = 8'($urandom_range(200, 254));
        default: thresh = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 5))
        0: key = 16'h0000;
        1: key = 16'hFFFF;
        default: key = 16'($urandom_range(0, 65535));
      endcase
      label_odds = $urandom_range(0, 10);
      frames = $urandom_range(1, 2);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        scale  = 5'($urandom_range(9, 31));
        s_eff  = (scale > MAX_SCALE) ? MAX_SCALE : int'(scale);
        width  = 12'(s_eff * $urandom_range(1, 2) + $urandom_range(0, 2));
        height = 12'(s_eff + $urandom_range(0, 2));
        frames = 1;
      end else if (pick == 1) begin
        scale  = 5'd0;
        width  = 12'($urandom_range(0, 12));
        height = 12'($urandom_range(0, 6));
      end else begin
        scale  = 5'($urandom_range(1, 4));
        width  = 12'($urandom_range(1, 16));
        height = 12'($urandom_range(1, 10));
      end
      configure(mode, thresh, key, scale, width, height);
      gaps_on = ($urandom_range(0, 3) != 0);
      n = sb.frame_size() * frames;
      send_pixels(n);
      random_items += n;
    end

    settle();
    if (sb.mismatches == 0 && sb.expected_blocks.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
